// ----- hw/rtl/gear_shift_sequencer_assert.svh -----
// Assertion macros used by the gear shift sequencer checker.
`ifndef GEAR_SHIFT_SEQUENCER_ASSERT_SVH
`define GEAR_SHIFT_SEQUENCER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gss_pkg.sv -----
// Types and constants shared by the gear shift sequencer modules.
package gss_pkg;

    localparam int GEAR_W    = 3;
    localparam int STOP_W    = 12;
    localparam int TORQUE_W  = 10;
    localparam int DRIVE_W   = 11;
    localparam int TICKS_W   = 20;
    localparam int AGE_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int OUT_TDATA_W = 24;

    localparam logic [TORQUE_W-1:0] TORQUE_LIMIT = 10'd1000;

    localparam logic [TORQUE_W-1:0] TORQUE_RESET    = 10'd250;
    localparam logic [STOP_W-1:0]   TOLERANCE_RESET = 12'd20;
    localparam logic [TICKS_W-1:0]  TIMEOUT_RESET   = 20'd200000;
    localparam logic [AGE_W-1:0]    MAX_AGE_RESET   = 16'd200;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_UP      = 2'd1,
        REQ_DOWN    = 2'd2,
        REQ_NEUTRAL = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_REJECTED = 3'd1,
        ST_STARTED  = 3'd2,
        ST_PROGRESS = 3'd3,
        ST_SHIFTED  = 3'd4,
        ST_FAULT    = 3'd5,
        ST_TIMEOUT  = 3'd6,
        ST_IGNORED  = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TORQUE      = 3'd0,
        CFG_UP_STOP     = 3'd1,
        CFG_DOWN_STOP   = 3'd2,
        CFG_N1_STOP     = 3'd3,
        CFG_N2_STOP     = 3'd4,
        CFG_TOLERANCE   = 3'd5,
        CFG_TIMEOUT     = 3'd6,
        CFG_MAX_AGE     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TORQUE_W-1:0] torque_magnitude;
        logic [STOP_W-1:0]   up_stop_position;
        logic [STOP_W-1:0]   down_stop_position;
        logic [STOP_W-1:0]   neutral_from_first_stop;
        logic [STOP_W-1:0]   neutral_from_second_stop;
        logic [STOP_W-1:0]   position_tolerance;
        logic [TICKS_W-1:0]  timeout_ticks;
        logic [AGE_W-1:0]    ecu_max_age;
    } cfg_t;

    // Result fields, status in the lowest bits to match the output packing.
    typedef struct packed {
        logic                       resynced;
        logic [GEAR_W-1:0]          current_gear;
        logic signed [DRIVE_W-1:0]  drive_torque;
        status_t                    status;
    } res_t;

endpackage

// ----- hw/rtl/gear_shift_sequencer.sv -----
// Top level of the gear shift sequencer: stream ports, settings and pipeline registers.
//
// The block runs one gearbox shift at a time. Every request takes one result: shift
// requests start or reject a shift and are ignored while one runs; sample requests move
// it on by one tick or end it, and are ignored when idle. A request passes through
// an input register and a result register before its result appears, and a new request
// can be taken in every cycle; the only throttle is the result channel, since the input
// register holds while a result waits on m_tready. The user must write settings through
// the cfg port while no request is in flight; the block does not enforce this.
module gear_shift_sequencer import gss_pkg::*; #(
    parameter int TOP_GEAR      = 5,
    parameter int POSITION_BITS = 12,
    localparam int S_TDATA_W    = ((22 + POSITION_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // request, reported gear, report age, encoder status, shaft position, zero padding
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status, drive_torque, current_gear, resynced, zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int POS_LO = 22;

    cfg_t                     cfg_reg;
    logic                     in_valid_reg;
    logic                     in_func_reg;
    req_t                     in_req_reg;
    logic [GEAR_W-1:0]        in_ecu_reg;
    logic [AGE_W-1:0]         in_age_reg;
    logic                     in_ok_reg;
    logic [POSITION_BITS-1:0] in_pos_reg;
    logic                     out_valid_reg;
    res_t                     out_reg;
    res_t                     step_res;
    logic                     advance;
    logic                     s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.torque_magnitude         <= TORQUE_RESET;
            cfg_reg.up_stop_position         <= '0;
            cfg_reg.down_stop_position       <= '0;
            cfg_reg.neutral_from_first_stop  <= '0;
            cfg_reg.neutral_from_second_stop <= '0;
            cfg_reg.position_tolerance       <= TOLERANCE_RESET;
            cfg_reg.timeout_ticks            <= TIMEOUT_RESET;
            cfg_reg.ecu_max_age              <= MAX_AGE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_TORQUE:    cfg_reg.torque_magnitude <= cfg_wr_data[TORQUE_W-1:0];
                CFG_UP_STOP:   cfg_reg.up_stop_position <= cfg_wr_data[STOP_W-1:0];
                CFG_DOWN_STOP: cfg_reg.down_stop_position <= cfg_wr_data[STOP_W-1:0];
                CFG_N1_STOP:   cfg_reg.neutral_from_first_stop <= cfg_wr_data[STOP_W-1:0];
                CFG_N2_STOP:   cfg_reg.neutral_from_second_stop <= cfg_wr_data[STOP_W-1:0];
                CFG_TOLERANCE: cfg_reg.position_tolerance <= cfg_wr_data[STOP_W-1:0];
                CFG_TIMEOUT:   cfg_reg.timeout_ticks <= cfg_wr_data[TICKS_W-1:0];
                CFG_MAX_AGE:   cfg_reg.ecu_max_age <= cfg_wr_data[AGE_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg <= s_tuser[0];
            in_req_reg  <= req_t'(s_tdata[1:0]);
            in_ecu_reg  <= s_tdata[4:2];
            in_age_reg  <= s_tdata[20:5];
            in_ok_reg   <= s_tdata[21];
            in_pos_reg  <= s_tdata[POS_LO +: POSITION_BITS];
        end
    end

    gss_core #(
        .TOP_GEAR      (TOP_GEAR),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .func      (in_func_reg),
        .request   (in_req_reg),
        .rpt_gear  (in_ecu_reg),
        .ecu_age   (in_age_reg),
        .pos_valid (in_ok_reg),
        .shaft_pos (in_pos_reg),
        .cfg       (cfg_reg),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(res_t))'(0), out_reg};

endmodule

// ----- hw/rtl/gss_core.sv -----
// Shift sequencing state and the per-item decision logic.
module gss_core import gss_pkg::*; #(
    parameter int TOP_GEAR      = 5,
    parameter int POSITION_BITS = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  logic                     func,
    input  req_t                     request,
    input  logic [GEAR_W-1:0]        rpt_gear,
    input  logic [AGE_W-1:0]         ecu_age,
    input  logic                     pos_valid,
    input  logic [POSITION_BITS-1:0] shaft_pos,
    input  cfg_t                     cfg,
    output res_t                     res
);

    localparam int DIST_W = (POSITION_BITS > STOP_W) ? POSITION_BITS : STOP_W;
    localparam logic [GEAR_W-1:0] TOP_GEAR_C = GEAR_W'(TOP_GEAR);

    logic                      actuating_reg, actuating_next;
    logic [GEAR_W-1:0]         gear_reg, gear_next;
    req_t                      active_req_reg, active_req_next;
    logic [TICKS_W-1:0]        elapsed_reg, elapsed_next;

    logic signed [DRIVE_W-1:0] mag;
    logic                      fresh;
    logic                      shift_legal;
    logic                      gear_match;
    logic [STOP_W-1:0]         target;
    logic [DIST_W-1:0]         pos_ext;
    logic [DIST_W-1:0]         tgt_ext;
    logic [DIST_W-1:0]         pos_gap;
    logic                      reached;
    logic [TICKS_W-1:0]        elapsed_inc;

    function automatic logic signed [DRIVE_W-1:0] drive_for(
        input req_t                      req,
        input logic [GEAR_W-1:0]         gear,
        input logic signed [DRIVE_W-1:0] m
    );
        logic signed [DRIVE_W-1:0] d;
        d = '0;
        case (req)
            REQ_UP:   d = m;
            REQ_DOWN: d = -m;
            REQ_NEUTRAL: begin
                if (gear == GEAR_W'(1)) begin
                    d = m;
                end else if (gear == GEAR_W'(2)) begin
                    d = -m;
                end
            end
            default:  d = '0;
        endcase
        return d;
    endfunction

    assign mag = (cfg.torque_magnitude > TORQUE_LIMIT)
               ? signed'({1'b0, TORQUE_LIMIT})
               : signed'({1'b0, cfg.torque_magnitude});

    assign fresh      = (ecu_age <= cfg.ecu_max_age);
    assign gear_match = fresh && (rpt_gear == gear_reg);

    always_comb begin
        case (request)
            REQ_UP:      shift_legal = (gear_reg < TOP_GEAR_C);
            REQ_DOWN:    shift_legal = (gear_reg > GEAR_W'(1));
            REQ_NEUTRAL: shift_legal = (gear_reg == GEAR_W'(1)) ||
                                       (gear_reg == GEAR_W'(2));
            default:     shift_legal = 1'b0;
        endcase
    end

    always_comb begin
        case (active_req_reg)
            REQ_UP:   target = cfg.up_stop_position;
            REQ_DOWN: target = cfg.down_stop_position;
            REQ_NEUTRAL: begin
                if (gear_reg == GEAR_W'(1)) begin
                    target = cfg.neutral_from_first_stop;
                end else if (gear_reg == GEAR_W'(2)) begin
                    target = cfg.neutral_from_second_stop;
                end else begin
                    target = '0;
                end
            end
            default:  target = '0;
        endcase
    end

    assign pos_ext     = DIST_W'(shaft_pos);
    assign tgt_ext     = DIST_W'(target);
    assign pos_gap     = (pos_ext >= tgt_ext) ? (pos_ext - tgt_ext) : (tgt_ext - pos_ext);
    assign reached     = (pos_gap <= DIST_W'(cfg.position_tolerance));
    assign elapsed_inc = elapsed_reg + TICKS_W'(1);

    always_comb begin
        actuating_next  = actuating_reg;
        gear_next       = gear_reg;
        active_req_next = active_req_reg;
        elapsed_next    = elapsed_reg;
        res.status       = ST_IGNORED;
        res.drive_torque = '0;
        res.resynced     = 1'b0;
        if (!func) begin
            if (actuating_reg) begin
                res.status       = ST_IGNORED;
                res.drive_torque = drive_for(active_req_reg, gear_reg, mag);
            end else if (request == REQ_NONE) begin
                res.status = ST_NONE;
            end else if (shift_legal && gear_match && pos_valid) begin
                actuating_next   = 1'b1;
                active_req_next  = request;
                elapsed_next     = '0;
                res.drive_torque = drive_for(request, gear_reg, mag);
                res.status       = ST_STARTED;
            end else begin
                // A fresh in-range report that disagrees pulls the gear over.
                if (fresh && (rpt_gear != gear_reg) && (rpt_gear <= TOP_GEAR_C)) begin
                    gear_next    = rpt_gear;
                    res.resynced = 1'b1;
                end
                res.status = ST_REJECTED;
            end
        end else begin
            if (!actuating_reg) begin
                res.status = ST_IGNORED;
            end else if (!pos_valid) begin
                res.status     = ST_FAULT;
                actuating_next = 1'b0;
            end else if (reached) begin
                case (active_req_reg)
                    REQ_UP:      gear_next = gear_reg + GEAR_W'(1);
                    REQ_DOWN:    gear_next = gear_reg - GEAR_W'(1);
                    REQ_NEUTRAL: gear_next = '0;
                    default:     gear_next = gear_reg;
                endcase
                res.status     = ST_SHIFTED;
                actuating_next = 1'b0;
            end else begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= cfg.timeout_ticks) begin
                    res.status     = ST_TIMEOUT;
                    actuating_next = 1'b0;
                end else begin
                    res.status       = ST_PROGRESS;
                    res.drive_torque = drive_for(active_req_reg, gear_reg, mag);
                end
            end
        end
        res.current_gear = gear_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            actuating_reg  <= 1'b0;
            gear_reg       <= '0;
            active_req_reg <= REQ_NONE;
            elapsed_reg    <= '0;
        end else if (step_en) begin
            actuating_reg  <= actuating_next;
            gear_reg       <= gear_next;
            active_req_reg <= active_req_next;
            elapsed_reg    <= elapsed_next;
        end
    end

endmodule

// ----- hw/rtl/gss_checker.sv -----
// Port-level assertions for the gear shift sequencer and their bind statement.
`include "gear_shift_sequencer_assert.svh"

module gss_checker import gss_pkg::*; #(
    parameter int TOP_GEAR = 5
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic [GEAR_W-1:0] TOP_GEAR_C = GEAR_W'(TOP_GEAR);

    status_t                   st;
    logic signed [DRIVE_W-1:0] drive;
    logic [GEAR_W-1:0]         gear;
    logic                      resync;

    assign st     = status_t'(m_tdata[2:0]);
    assign drive  = signed'(m_tdata[13:3]);
    assign gear   = m_tdata[16:14];
    assign resync = m_tdata[17];

    `GSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `GSS_ASSERT_SAME(a_idle_drive, m_tvalid && (st == ST_NONE || st == ST_REJECTED || st == ST_SHIFTED || st == ST_FAULT || st == ST_TIMEOUT), drive == '0, "drive not zero after shift ended")
    `GSS_ASSERT_SAME(a_resync_reject, m_tvalid && resync, st == ST_REJECTED, "resync without rejection")
    `GSS_ASSERT_SAME(a_gear_range, m_tvalid, gear <= TOP_GEAR_C, "gear above top gear")
    `GSS_ASSERT_SAME(a_ready_flow, m_tready, s_tready, "input stalled while output drains")

endmodule

bind gear_shift_sequencer gss_checker #(.TOP_GEAR(TOP_GEAR)) u_gss_checker (.*);
